// ----- design/yuyv_frame_to_rgb_decoder_top_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef YUYV_FRAME_TO_RGB_DECODER_TOP_ASSERT_SVH
`define YUYV_FRAME_TO_RGB_DECODER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define YFR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// A condition that must hold in the same cycle as a trigger.
`define YFR_ASSERT_IMPLIES(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("assertion failed");

// A condition that must hold in the cycle after a trigger.
`define YFR_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// ----- design/yfr_pkg.sv -----
// Types and constants of the YUYV frame decoder.
package yfr_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int AREA_BITS   = WIDTH_BITS + HEIGHT_BITS;
   localparam int CMP_BITS    = (AREA_BITS + 1 > 32) ? AREA_BITS + 1 : 32;

   localparam logic [31:0] MAX_WIDTH_WORD  = 32'(MAX_WIDTH);
   localparam logic [31:0] MAX_HEIGHT_WORD = 32'(MAX_HEIGHT);

   // Header layout: byte positions that close each little-endian word.
   localparam logic [3:0] HDR_MAGIC_LEN   = 4'd4;
   localparam logic [3:0] HDR_WIDTH_LAST  = 4'd7;
   localparam logic [3:0] HDR_HEIGHT_LAST = 4'd11;
   localparam logic [3:0] HDR_COUNT_LAST  = 4'd15;

   localparam logic [7:0] MAGIC [4] = '{8'h59, 8'h55, 8'h56, 8'h30};

   // BT.601 integer coefficients.
   localparam logic signed [19:0] K_Y      = 20'sd298;
   localparam logic signed [19:0] K_RV     = 20'sd409;
   localparam logic signed [19:0] K_GU     = 20'sd100;
   localparam logic signed [19:0] K_GV     = 20'sd208;
   localparam logic signed [19:0] K_BU     = 20'sd516;
   localparam logic signed [19:0] K_ROUND  = 20'sd128;
   localparam logic signed [19:0] K_CHROMA = 20'sd128;
   localparam logic [7:0]         Y_OFFSET = 8'd16;
   localparam logic [7:0]         CH_MAX   = 8'd255;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_HEADER = 2'd1,
      ERR_FIELDS = 2'd2,
      ERR_SHORT  = 2'd3
   } err_code_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXELS = 2'd1,
      PH_IGNORE = 2'd2
   } phase_type;

   // Everything one input byte produces: an optional pixel pair and an optional error.
   typedef struct packed {
      logic         has_pix;
      logic         has_err;
      err_code_type err_code;
      logic [7:0]   y0;
      logic [7:0]   u;
      logic [7:0]   y1;
      logic [7:0]   v;
      logic         eor;
      logic         eof;
   } bundle_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

endpackage

// ----- design/yuyv_frame_to_rgb_decoder_top.sv -----
// Header-checking YUYV 4:2:2 to RGB decoder, one payload byte per transfer.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  data_byte, end_of_payload
//   rsp_     out        rsp_valid/rsp_ready  kind, red/green/blue, error_code, end flags
//
// One byte is taken per cycle while req_ready is high; the header and group state updates in that cycle.
// A byte that completes a pixel group adds two results and possibly an error, which
// leave one per cycle while rsp_ready is high, from a two-entry result queue.
// Four bytes make two pixels, so the queue keeps pace at one byte per cycle.
// Reset is synchronous; there is no clearing pass.
// A low rsp_ready fills the queue; req_ready falls only while both entries are held.
`include "yuyv_frame_to_rgb_decoder_top_assert.svh"

module yuyv_frame_to_rgb_decoder_top
   import yfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [1:0] rsp_error_code,
   output logic       rsp_end_of_row,
   output logic       rsp_end_of_frame,
   output logic       rsp_last_in_run
);

   // Parse state.
   phase_type               phase_ff, phase_in;
   logic [3:0]              header_index_ff, header_index_in;
   logic [23:0]             header_word_ff, header_word_in;
   logic [WIDTH_BITS-1:0]   frame_width_ff, frame_width_in;
   logic [HEIGHT_BITS-1:0]  frame_height_ff, frame_height_in;
   logic                    width_ok_ff, width_ok_in;
   logic                    height_ok_ff, height_ok_in;
   logic [AREA_BITS-1:0]    area_ff, area_in;
   logic [1:0]              group_index_ff, group_index_in;
   logic [23:0]             group_bytes_ff, group_bytes_in;
   logic [WIDTH_BITS-1:0]   column_ff, column_in;
   logic [HEIGHT_BITS-1:0]  row_ff, row_in;

   bundle_type              bundle_in;
   logic                    req_accept;
   logic [31:0]             word_full;
   logic                    eor;
   logic                    eof;

   // Result queue.
   bundle_type              fifo_ff [2];
   logic                    wr_ptr_ff, rd_ptr_ff;
   logic [1:0]              fifo_count_ff;
   logic [1:0]              sel_ff, sel_in;
   logic                    push, pop, load;
   bundle_type              head;
   logic                    head_last;
   logic                    head_is_pixel;
   rgb_type                 head_rgb;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff;
   rgb_type                 rsp_rgb_ff;
   err_code_type            rsp_error_code_ff;
   logic                    rsp_end_of_row_ff;
   logic                    rsp_end_of_frame_ff;
   logic                    rsp_last_in_run_ff;

   function automatic logic [7:0] clamp_channel(input logic signed [19:0] t);
      logic [7:0] res;
      if (t[19]) begin
         res = '0;
      end else if (t[18:16] != 3'd0) begin
         res = CH_MAX;
      end else begin
         res = t[15:8];
      end
      return res;
   endfunction

   function automatic rgb_type yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                          input logic [7:0] v);
      logic signed [19:0] c;
      logic signed [19:0] us;
      logic signed [19:0] vs;
      rgb_type            res;
      c  = (y >= Y_OFFSET) ? signed'(20'(y - Y_OFFSET)) : '0;
      us = signed'(20'(u)) - K_CHROMA;
      vs = signed'(20'(v)) - K_CHROMA;
      res.red   = clamp_channel(K_Y * c + K_RV * vs + K_ROUND);
      res.green = clamp_channel(K_Y * c - K_GU * us - K_GV * vs + K_ROUND);
      res.blue  = clamp_channel(K_Y * c + K_BU * us + K_ROUND);
      return res;
   endfunction

   assign req_ready  = (fifo_count_ff != 2'd2);
   assign req_accept = req_valid && req_ready;
   assign word_full  = {req_data_byte, header_word_ff};

   assign eor = ({1'b0, column_ff} + (WIDTH_BITS + 1)'(2)) >= {1'b0, frame_width_ff};
   assign eof = eor && (({1'b0, row_ff} + (HEIGHT_BITS + 1)'(1)) >= {1'b0, frame_height_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_index_ff <= '0;
         header_word_ff  <= '0;
         group_index_ff  <= '0;
         column_ff       <= '0;
         row_ff          <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         header_word_ff  <= header_word_in;
         group_index_ff  <= group_index_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_width_ff  <= frame_width_in;
      frame_height_ff <= frame_height_in;
      width_ok_ff     <= width_ok_in;
      height_ok_ff    <= height_ok_in;
      area_ff         <= area_in;
      group_bytes_ff  <= group_bytes_in;
   end

   // Next parse state and the results of the accepted byte.
   always_comb begin
      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      header_word_in  = header_word_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      width_ok_in     = width_ok_ff;
      height_ok_in    = height_ok_ff;
      area_in         = area_ff;
      group_index_in  = group_index_ff;
      group_bytes_in  = group_bytes_ff;
      column_in       = column_ff;
      row_in          = row_ff;
      bundle_in       = '0;
      bundle_in.err_code = ERR_NONE;

      if (req_accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (header_index_ff < HDR_MAGIC_LEN &&
                   req_data_byte != MAGIC[header_index_ff[1:0]]) begin
                  bundle_in.has_err  = 1'b1;
                  bundle_in.err_code = ERR_HEADER;
                  phase_in = PH_IGNORE;
               end else begin
                  if (header_index_ff[1:0] == 2'd3) begin
                     header_word_in = '0;
                  end else begin
                     header_word_in[8 * header_index_ff[1:0] +: 8] = req_data_byte;
                  end
                  header_index_in = header_index_ff + 4'd1;

                  if (header_index_ff == HDR_WIDTH_LAST) begin
                     frame_width_in = word_full[WIDTH_BITS-1:0];
                     width_ok_in    = (word_full != '0) && !word_full[0] &&
                                      (word_full <= MAX_WIDTH_WORD);
                  end
                  if (header_index_ff == HDR_HEIGHT_LAST) begin
                     frame_height_in = word_full[HEIGHT_BITS-1:0];
                     height_ok_in    = (word_full != '0) && (word_full <= MAX_HEIGHT_WORD);
                     area_in         = AREA_BITS'(frame_width_ff) *
                                       AREA_BITS'(word_full[HEIGHT_BITS-1:0]);
                  end

                  if (header_index_ff == HDR_COUNT_LAST) begin
                     // The byte count must be exactly two bytes per pixel.
                     if (!width_ok_ff || !height_ok_ff ||
                         CMP_BITS'(word_full) != CMP_BITS'({area_ff, 1'b0})) begin
                        bundle_in.has_err  = 1'b1;
                        bundle_in.err_code = ERR_FIELDS;
                        phase_in = PH_IGNORE;
                     end else begin
                        phase_in       = PH_PIXELS;
                        group_index_in = '0;
                        column_in      = '0;
                        row_in         = '0;
                        if (req_end_of_payload) begin
                           bundle_in.has_err  = 1'b1;
                           bundle_in.err_code = ERR_SHORT;
                        end
                     end
                  end else if (req_end_of_payload) begin
                     bundle_in.has_err  = 1'b1;
                     bundle_in.err_code = ERR_HEADER;
                  end
               end
            end

            PH_PIXELS: begin
               if (group_index_ff != 2'd3) begin
                  group_bytes_in[8 * group_index_ff +: 8] = req_data_byte;
                  group_index_in = group_index_ff + 2'd1;
               end else begin
                  bundle_in.has_pix = 1'b1;
                  bundle_in.y0      = group_bytes_ff[7:0];
                  bundle_in.u       = group_bytes_ff[15:8];
                  bundle_in.y1      = group_bytes_ff[23:16];
                  bundle_in.v       = req_data_byte;
                  bundle_in.eor     = eor;
                  bundle_in.eof     = eof;
                  group_index_in    = '0;
                  if (eor) begin
                     column_in = '0;
                     row_in    = row_ff + HEIGHT_BITS'(1);
                  end else begin
                     column_in = column_ff + WIDTH_BITS'(2);
                  end
                  if (eof) begin
                     phase_in = PH_IGNORE;
                  end
               end
               if (req_end_of_payload && !(group_index_ff == 2'd3 && eof)) begin
                  bundle_in.has_err  = 1'b1;
                  bundle_in.err_code = ERR_SHORT;
               end
            end

            default: begin
            end
         endcase

         if (req_end_of_payload) begin
            phase_in        = PH_HEADER;
            header_index_in = '0;
            header_word_in  = '0;
            group_index_in  = '0;
         end
      end
   end

   // Two-entry queue of per-byte result bundles.
   assign push = req_accept && (bundle_in.has_pix || bundle_in.has_err);
   assign head = fifo_ff[rd_ptr_ff];
   assign load = (fifo_count_ff != 2'd0) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      // Pixels come first (slots 0 and 1), then the error, if any.
      head_is_pixel = head.has_pix && (sel_ff != 2'd2);
      if (head.has_err) begin
         head_last = (sel_ff == (head.has_pix ? 2'd2 : 2'd0));
      end else begin
         head_last = (sel_ff == 2'd1);
      end
      pop    = load && head_last;
      sel_in = sel_ff;
      if (load) begin
         sel_in = head_last ? 2'd0 : sel_ff + 2'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign head_rgb = yuv_to_rgb(sel_ff[0] ? head.y1 : head.y0, head.u, head.v);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= bundle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         fifo_count_ff <= '0;
         sel_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fifo_count_ff <= fifo_count_ff + 2'd1;
            2'b01:   fifo_count_ff <= fifo_count_ff - 2'd1;
            default: fifo_count_ff <= fifo_count_ff;
         endcase
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_last_in_run_ff <= head_last;
         if (head_is_pixel) begin
            rsp_kind_ff         <= KIND_PIXEL;
            rsp_rgb_ff          <= head_rgb;
            rsp_error_code_ff   <= ERR_NONE;
            rsp_end_of_row_ff   <= sel_ff[0] && head.eor;
            rsp_end_of_frame_ff <= sel_ff[0] && head.eof;
         end else begin
            rsp_kind_ff         <= KIND_ERROR;
            rsp_rgb_ff          <= '0;
            rsp_error_code_ff   <= head.err_code;
            rsp_end_of_row_ff   <= 1'b0;
            rsp_end_of_frame_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_red          = rsp_rgb_ff.red;
   assign rsp_green        = rsp_rgb_ff.green;
   assign rsp_blue         = rsp_rgb_ff.blue;
   assign rsp_error_code   = rsp_error_code_ff;
   assign rsp_end_of_row   = rsp_end_of_row_ff;
   assign rsp_end_of_frame = rsp_end_of_frame_ff;
   assign rsp_last_in_run  = rsp_last_in_run_ff;

   `YFR_ASSERT_ALWAYS(a_fifo_bound, fifo_count_ff <= 2'd2)
   `YFR_ASSERT_IMPLIES(a_sel_needs_bundle, sel_ff != 2'd0, fifo_count_ff != 2'd0)
   `YFR_ASSERT_IMPLIES(a_eof_closes_row, rsp_valid && rsp_end_of_frame, rsp_end_of_row)
   `YFR_ASSERT_IMPLIES(a_pixel_no_code, rsp_valid && rsp_kind == KIND_PIXEL,
                       rsp_error_code == ERR_NONE)
   `YFR_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !rsp_last_in_run, rsp_valid)

endmodule
